// ===== rtl/fundamental_inlier_scoring_assert.svh =====
// ----------------------------------------------------------------------------
// fundamental_inlier_scoring_assert.svh
// assertion macros for the checker file fis_chk.sv
// ----------------------------------------------------------------------------
`ifndef FUNDAMENTAL_INLIER_SCORING_ASSERT_SVH
`define FUNDAMENTAL_INLIER_SCORING_ASSERT_SVH

// same-cycle implication
`define FIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fis_pkg.sv =====
// ----------------------------------------------------------------------------
// fis_pkg
// shared types and constants of the epipolar inlier scoring block
// ----------------------------------------------------------------------------
package fis_pkg;

  localparam int ACC_W  = 120;
  localparam int MOP_W  = 33;
  localparam int PROD_W = 66;
  localparam int CHI_W  = 24;
  localparam int NUM_W  = 116;
  localparam int DEN_W  = 59;
  localparam int SQ_W   = 92;
  localparam int MN_W   = 64;
  localparam int CFG_W  = 64;
  localparam int F_W    = 32;
  localparam int ISQ_W  = 24;

  localparam logic [CHI_W-1:0] CHI_TH    = 24'd251724;
  localparam logic [CHI_W-1:0] CHI_SCORE = 24'd392626;
  localparam logic [CHI_W-1:0] CHI_MAX   = 24'hFFFFFF;
  localparam logic [CHI_W-1:0] MIN_INLIER_SCORE = 24'd281804;
  localparam logic [57:0]      C_LIMIT   = 58'd1 << 57;

  typedef enum logic [2:0] {
    CFG_ROW1_AB,
    CFG_ROW12_CA,
    CFG_ROW2_BC,
    CFG_ROW3_AB,
    CFG_ROW3_C,
    CFG_INV_SIGMA_SQ
  } fis_cfg_idx_e;

  typedef enum logic [2:0] {
    SH_0,
    SH_24,
    SH_32,
    SH_46,
    SH_64
  } fis_shift_e;

  typedef struct packed {
    logic                    vld;
    logic signed [MOP_W-1:0] opa;
    logic signed [MOP_W-1:0] opb;
    fis_shift_e              sh;
  } fis_mul_req_t;

  typedef struct packed {
    logic                     vld;
    logic signed [PROD_W-1:0] prod;
    fis_shift_e               sh;
  } fis_mul_rsp_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [CHI_W-1:0] quo;
  } fis_div_rsp_t;

endpackage

// ===== rtl/fis_mul.sv =====
// ----------------------------------------------------------------------------
// fis_mul
// shared signed multiplier with registered product and shift tag
// ----------------------------------------------------------------------------
module fis_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fis_pkg::fis_mul_req_t req_i,
  output fis_pkg::fis_mul_rsp_t rsp_o
);
  import fis_pkg::*;

  logic                     vld_q;
  logic signed [PROD_W-1:0] prod_q;
  fis_shift_e               sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.opa * req_i.opb;
    sh_q   <= req_i.sh;
  end

  assign rsp_o = '{vld: vld_q, prod: prod_q, sh: sh_q};

endmodule

// ===== rtl/fis_div.sv =====
// ----------------------------------------------------------------------------
// fis_div
// restoring divider, one quotient bit per cycle, for the chi value
// ----------------------------------------------------------------------------
module fis_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fis_pkg::NUM_W-1:0]    num_i,
  input  logic [fis_pkg::DEN_W-1:0]    den_i,
  output fis_pkg::fis_div_rsp_t        rsp_o
);
  import fis_pkg::*;

  localparam int DV_W = DEN_W + 32;

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic              sat_q;
  logic [CHI_W-1:0]  quo_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DV_W-1:0]   dv_q;
  logic              ge;

  assign ge = rem_q >= NUM_W'(dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd24;
      end else if (busy_q) begin
        if (cnt_q == 5'd24) begin
          if (ge) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= 5'd23;
          end
        end else if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dv_q  <= {den_i, 32'b0};
      sat_q <= 1'b0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 5'd24) begin
        sat_q <= ge;
        dv_q  <= dv_q >> 1;
      end else begin
        if (ge) begin
          rem_q <= rem_q - NUM_W'(dv_q);
        end
        quo_q <= {quo_q[CHI_W-2:0], ge};
        dv_q  <= dv_q >> 1;
      end
    end
  end

  assign rsp_o = '{done: done_q, sat: sat_q, quo: quo_q};

endmodule

// ===== rtl/fundamental_inlier_scoring.sv =====
// latency: least when both lines have zero norm, as each direction then skips
//   the distance and divide steps; the two directions run one after the other
// throughput: one match at a time, a new match is taken once the last one is done
// the shared 33x33 multiplier and the one-bit-per-cycle chi divider set the latency
// reset: score cleared, F entries zero, inverse sigma squared 1.0, output empty
// ----------------------------------------------------------------------------
// fundamental_inlier_scoring
// symmetric epipolar distance chi-square test with running inlier score
// ----------------------------------------------------------------------------
module fundamental_inlier_scoring #(
  parameter int COORD_BITS = 16,
  parameter int SCORE_BITS = 36
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // set_start
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // running_score
  output logic [((SCORE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // is_inlier
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [fis_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import fis_pkg::*;

  localparam int OUT_W = ((SCORE_BITS+7)/8)*8;
  localparam int MAG_W = COORD_BITS + 33;
  localparam int MC_W  = (MAG_W > 58) ? MAG_W : 58;

  typedef enum logic [4:0] {
    ST_IDLE, ST_L0, ST_L1, ST_L2, ST_CST, ST_NORM,
    ST_N0, ST_N1, ST_N2, ST_D0, ST_D1, ST_D2, ST_D3,
    ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_P0, ST_P1, ST_P2, ST_P3,
    ST_DS, ST_DIV, ST_SC, ST_OUT
  } fis_st_e;

  // configuration
  logic [CFG_W-1:0] row_q [4];
  logic [F_W-1:0]   f33_q;
  logic [ISQ_W-1:0] isq_q;
  logic [F_W-1:0]   fm [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        row_q[i] <= '0;
      end
      f33_q <= '0;
      isq_q <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW1_AB:      row_q[0] <= cfg_wdata_i;
        CFG_ROW12_CA:     row_q[1] <= cfg_wdata_i;
        CFG_ROW2_BC:      row_q[2] <= cfg_wdata_i;
        CFG_ROW3_AB:      row_q[3] <= cfg_wdata_i;
        CFG_ROW3_C:       f33_q    <= cfg_wdata_i[F_W-1:0];
        CFG_INV_SIGMA_SQ: isq_q    <= cfg_wdata_i[ISQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fm[2*i]   = row_q[i][CFG_W-1:F_W];
      fm[2*i+1] = row_q[i][F_W-1:0];
    end
    fm[8] = f33_q;
  end

  function automatic logic [3:0] fidx(input logic tr, input logic [1:0] k, input logic [1:0] j);
    fidx = tr ? (4'(j) * 4'd3 + 4'(k)) : (4'(k) * 4'd3 + 4'(j));
  endfunction

  function automatic logic signed [ACC_W-1:0] align(input logic signed [PROD_W-1:0] p,
                                                    input fis_shift_e s);
    logic signed [ACC_W-1:0] e;
    e = ACC_W'(p);
    case (s)
      SH_24:   align = e <<< 24;
      SH_32:   align = e <<< 32;
      SH_46:   align = e <<< 46;
      SH_64:   align = e <<< 64;
      default: align = e;
    endcase
  endfunction

  // state and datapath
  fis_st_e                 st_q;
  logic                    dir_q;
  logic [1:0]              row_sel_q;
  logic                    zero_q;
  logic                    fail_q;
  logic [SCORE_BITS-1:0]   score_q;
  logic                    out_v_q;
  logic                    out_inl_q;
  logic [SCORE_BITS-1:0]   out_score_q;

  logic [COORD_BITS-1:0]   u1_q, v1_q, u2_q, v2_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_base;
  logic [ACC_W-1:0]        acc_mag;
  logic [MAG_W-1:0]        ma_q, mb_q, mx;
  logic [MC_W-1:0]         mc_q;
  logic                    sa_q, sb_q, sc_q;
  logic [MN_W-1:0]         mn_q;
  logic [DEN_W-1:0]        den_q;
  logic [SQ_W-1:0]         sq_q;
  logic [CHI_W-1:0]        chi_q;

  logic [COORD_BITS-1:0]   px, py, qx, qy;
  logic [F_W-1:0]          c0, c1, c2;
  logic signed [MOP_W-1:0] ma_op, mb_op, isq_op, hi_op, lo_op;
  logic                    norm_r4, norm_r1, norm_l4, norm_l1;
  logic [CHI_W-1:0]        gain;
  logic [SCORE_BITS:0]     score_sum;

  fis_mul_req_t mul_req;
  fis_mul_rsp_t mul_rsp;
  fis_div_rsp_t div_rsp;

  assign px = dir_q ? u2_q : u1_q;
  assign py = dir_q ? v2_q : v1_q;
  assign qx = dir_q ? u1_q : u2_q;
  assign qy = dir_q ? v1_q : v2_q;
  assign c0 = fm[fidx(dir_q, row_sel_q, 2'd0)];
  assign c1 = fm[fidx(dir_q, row_sel_q, 2'd1)];
  assign c2 = fm[fidx(dir_q, row_sel_q, 2'd2)];

  assign ma_op  = MOP_W'(ma_q[28:0]);
  assign mb_op  = MOP_W'(mb_q[28:0]);
  assign isq_op = MOP_W'(isq_q);
  assign hi_op  = MOP_W'(mn_q[45:23]);
  assign lo_op  = MOP_W'(mn_q[22:0]);

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign mx      = (ma_q > mb_q) ? ma_q : mb_q;
  assign norm_r4 = mx[MAG_W-1:33] != '0;
  assign norm_r1 = mx[MAG_W-1:29] != '0;
  assign norm_l4 = mx[MAG_W-1:25] == '0;
  assign norm_l1 = mx[MAG_W-1:28] == '0;

  assign gain      = CHI_SCORE - chi_q;
  assign score_sum = {1'b0, score_q} + (SCORE_BITS+1)'(gain);

  always_comb begin
    mul_req = '{vld: 1'b0, opa: '0, opb: '0, sh: SH_0};
    case (st_q)
      ST_L0: mul_req = '{vld: 1'b1, opa: MOP_W'($signed(c0)),
                         opb: MOP_W'(px), sh: SH_0};
      ST_L1: mul_req = '{vld: 1'b1, opa: MOP_W'($signed(c1)),
                         opb: MOP_W'(py), sh: SH_0};
      ST_N0: mul_req = '{vld: 1'b1, opa: sa_q ? -ma_op : ma_op,
                         opb: MOP_W'(qx), sh: SH_0};
      ST_N1: mul_req = '{vld: 1'b1, opa: sb_q ? -mb_op : mb_op,
                         opb: MOP_W'(qy), sh: SH_0};
      ST_D0: mul_req = '{vld: 1'b1, opa: ma_op, opb: ma_op, sh: SH_0};
      ST_D1: mul_req = '{vld: 1'b1, opa: mb_op, opb: mb_op, sh: SH_0};
      ST_Q0: mul_req = '{vld: 1'b1, opa: hi_op, opb: hi_op, sh: SH_46};
      ST_Q1: mul_req = '{vld: 1'b1, opa: hi_op, opb: lo_op, sh: SH_24};
      ST_Q2: mul_req = '{vld: 1'b1, opa: lo_op, opb: lo_op, sh: SH_0};
      ST_P0: mul_req = '{vld: 1'b1, opa: MOP_W'(acc_q[31:0]), opb: isq_op, sh: SH_0};
      ST_P1: mul_req = '{vld: 1'b1, opa: MOP_W'(sq_q[63:32]), opb: isq_op, sh: SH_32};
      ST_P2: mul_req = '{vld: 1'b1, opa: MOP_W'(sq_q[SQ_W-1:64]), opb: isq_op, sh: SH_64};
      default: ;
    endcase
  end

  always_comb begin
    case (st_q)
      ST_L0:                acc_base = {{(ACC_W-F_W-4){c2[F_W-1]}}, c2, 4'b0};
      ST_N0:                acc_base = sc_q ? -$signed({{(ACC_W-MC_W-4){1'b0}}, mc_q, 4'b0})
                                            : $signed({{(ACC_W-MC_W-4){1'b0}}, mc_q, 4'b0});
      ST_D0, ST_Q0, ST_P0:  acc_base = '0;
      default:              acc_base = acc_q;
    endcase
    acc_d = acc_base + (mul_rsp.vld ? align(mul_rsp.prod, mul_rsp.sh) : '0);
  end

  fis_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == ST_DS),
    .num_i   (acc_q[NUM_W-1:0]),
    .den_i   (den_q),
    .rsp_o   (div_rsp)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (st_q == ST_IDLE && s_axis_tvalid) begin
      u1_q <= s_axis_tdata[COORD_BITS-1:0];
      v1_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      u2_q <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      v2_q <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
    case (st_q)
      ST_L0: begin
        if (row_sel_q == 2'd1) begin
          ma_q <= acc_mag[MAG_W-1:0];
          sa_q <= acc_q[ACC_W-1];
        end else if (row_sel_q == 2'd2) begin
          mb_q <= acc_mag[MAG_W-1:0];
          sb_q <= acc_q[ACC_W-1];
        end
      end
      ST_CST: begin
        mc_q <= acc_mag[MC_W-1:0];
        sc_q <= acc_q[ACC_W-1];
      end
      ST_NORM: begin
        if (norm_r4) begin
          ma_q <= ma_q >> 4;
          mb_q <= mb_q >> 4;
          mc_q <= mc_q >> 4;
        end else if (norm_r1) begin
          ma_q <= ma_q >> 1;
          mb_q <= mb_q >> 1;
          mc_q <= mc_q >> 1;
        end else if (norm_l4) begin
          ma_q <= ma_q << 4;
          mb_q <= mb_q << 4;
          mc_q <= (mc_q[MC_W-1:53] != '0) ? MC_W'(C_LIMIT) : mc_q << 4;
        end else if (norm_l1) begin
          ma_q <= ma_q << 1;
          mb_q <= mb_q << 1;
          mc_q <= (mc_q[MC_W-1:56] != '0) ? MC_W'(C_LIMIT) : mc_q << 1;
        end
      end
      ST_D0: mn_q  <= acc_mag[MN_W-1:0];
      ST_D3: begin
        den_q <= acc_q[DEN_W-1:0];
        if (isq_q == '0) begin
          chi_q <= '0;
        end else if (mn_q[MN_W-1:46] != '0) begin
          chi_q <= CHI_MAX;
        end
      end
      ST_P0: sq_q <= acc_q[SQ_W-1:0];
      ST_DIV: begin
        if (div_rsp.done) begin
          chi_q <= div_rsp.sat ? CHI_MAX : div_rsp.quo;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      dir_q       <= 1'b0;
      row_sel_q   <= '0;
      zero_q      <= 1'b0;
      fail_q      <= 1'b0;
      score_q     <= '0;
      out_v_q     <= 1'b0;
      out_inl_q   <= 1'b0;
      out_score_q <= '0;
    end else begin
      if (out_v_q && m_axis_tready && st_q != ST_OUT) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dir_q     <= 1'b0;
            row_sel_q <= '0;
            fail_q    <= 1'b0;
            if (s_axis_tuser) begin
              score_q <= '0;
            end
            st_q <= ST_L0;
          end
        end
        ST_L0:   st_q <= ST_L1;
        ST_L1:   st_q <= ST_L2;
        ST_L2: begin
          if (row_sel_q == 2'd2) begin
            st_q <= ST_CST;
          end else begin
            row_sel_q <= row_sel_q + 2'd1;
            st_q      <= ST_L0;
          end
        end
        ST_CST: begin
          zero_q <= (mx == '0);
          st_q   <= (mx == '0) ? ST_SC : ST_NORM;
        end
        ST_NORM: begin
          if (!norm_r1 && !norm_l1) begin
            st_q <= ST_N0;
          end
        end
        ST_N0:   st_q <= ST_N1;
        ST_N1:   st_q <= ST_N2;
        ST_N2:   st_q <= ST_D0;
        ST_D0:   st_q <= ST_D1;
        ST_D1:   st_q <= ST_D2;
        ST_D2:   st_q <= ST_D3;
        ST_D3: begin
          if (isq_q == '0 || mn_q[MN_W-1:46] != '0) begin
            st_q <= ST_SC;
          end else begin
            st_q <= ST_Q0;
          end
        end
        ST_Q0:   st_q <= ST_Q1;
        ST_Q1:   st_q <= ST_Q2;
        ST_Q2:   st_q <= ST_Q3;
        ST_Q3:   st_q <= ST_P0;
        ST_P0:   st_q <= ST_P1;
        ST_P1:   st_q <= ST_P2;
        ST_P2:   st_q <= ST_P3;
        ST_P3:   st_q <= ST_DS;
        ST_DS:   st_q <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            st_q <= ST_SC;
          end
        end
        ST_SC: begin
          if (zero_q || chi_q > CHI_TH) begin
            fail_q <= 1'b1;
          end else begin
            score_q <= score_sum[SCORE_BITS] ? '1 : score_sum[SCORE_BITS-1:0];
          end
          if (!dir_q) begin
            dir_q     <= 1'b1;
            row_sel_q <= '0;
            st_q      <= ST_L0;
          end else begin
            st_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q     <= 1'b1;
            out_inl_q   <= !fail_q;
            out_score_q <= score_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_inl_q;
  assign m_axis_tdata  = OUT_W'(out_score_q);

endmodule

// ===== rtl/fis_chk.sv =====
// ----------------------------------------------------------------------------
// fis_chk
// port-level checks of the inlier scoring block, bound to the top level
// ----------------------------------------------------------------------------
`include "fundamental_inlier_scoring_assert.svh"

module fis_chk #(
  parameter int SCORE_BITS = 36
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SCORE_BITS+7)/8)*8-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);
  import fis_pkg::*;

  `FIS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a match is in work")
  `FIS_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared one cycle after accept")
  `FIS_ASSERT_NOW(a_inlier_min_score, m_axis_tvalid && m_axis_tuser, m_axis_tdata[SCORE_BITS-1:0] >= SCORE_BITS'(MIN_INLIER_SCORE), "inlier beat with too low a score")
  `FIS_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind fundamental_inlier_scoring fis_chk #(.SCORE_BITS(SCORE_BITS)) u_fis_chk (.*);
